>>> hw/rtl/cfba_pkg.sv
// types and constants shared by the contiguous allocator and its testbench
`default_nettype none

package cfba_pkg;

    localparam int FIELD_W    = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_COMPACT = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MEMORY_SIZE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BEST_FIT_MODE = CFG_INDEX_W'(1);

    localparam logic [FIELD_W-1:0] MEM_SIZE_RESET = 16'd1024;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FIELD_W-1:0] block_id;
        logic [FIELD_W-1:0] block_size;
    } cfba_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] placed_start;
    } cfba_resp_t;

endpackage

`default_nettype wire

>>> hw/rtl/contiguous_first_best_fit_allocator_unit.sv
// contiguous first-fit / best-fit block allocator with free and compaction
//
// usage: a request transaction on s_valid/s_ready carries operation, block_id and
// block_size; each request gives exactly one response transaction on m_valid/m_ready
// with status and placed_start. configuration writes arrive on cfg_valid/cfg_ready
// (cfg_index 0 memory_size, 1 best_fit_mode) and are taken in any cycle; they are
// meant to be issued only while no request is in flight.
// throughput: one request at a time; the next request is not taken before the
// response is loaded. the work is set by the walk over the block table in address
// order: one table memory read and one pass through the shared adder per block
// (two for allocate: hole size, then block end).
// reset: aresetn (synchronous, active low) empties the table, restores
// memory_size to 1024 and selects first fit.
// stalls: the response sits in an output register; s_ready returns once the
// response is loaded, so one new request can be worked while it waits, and a
// finished result waits in its done state until the output register is free.
`default_nettype none

module contiguous_first_best_fit_allocator_unit
    import cfba_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int ADDR_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire cfba_req_t              s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output cfba_resp_t                  m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // slot index, table position (0..SLOTS) and arithmetic widths
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = $clog2(SLOTS + 1);
    localparam int CW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_HOLE,
        S_TAIL,
        S_PICK,
        S_COMMIT,
        S_FREE,
        S_CMPCT,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [PW-1:0]      count_reg;      // live blocks
    logic [PW-1:0]      k_reg;          // position in address order
    cfba_req_t          req_reg;
    logic [IW-1:0]      free_slot_reg;
    logic [CW-1:0]      prev_end_reg;
    logic [CW-1:0]      gap_reg;
    logic [CW-1:0]      cand_pos_reg;
    logic [PW-1:0]      cand_ins_reg;
    logic [CW-1:0]      best_gap_reg;
    logic [CW-1:0]      best_pos_reg;
    logic [PW-1:0]      best_ins_reg;
    logic               hole_valid_reg;
    logic               tail_reg;
    logic               found_reg;
    cfba_resp_t         res_reg;
    cfba_resp_t         m_data_reg;
    logic               m_valid_reg;
    logic [FIELD_W-1:0] mem_size_reg;
    logic               best_fit_reg;

    // address order: first count_reg entries are live slots sorted by start,
    // the rest are the free slots
    logic [IW-1:0] ord_reg [SLOTS];

    // block table
    logic [FIELD_W-1:0]   ident_mem [SLOTS];
    logic [ADDR_BITS-1:0] begin_mem [SLOTS];
    logic [ADDR_BITS-1:0] len_mem   [SLOTS];
    logic [FIELD_W-1:0]   rd_ident_reg;
    logic [ADDR_BITS-1:0] rd_begin_reg;
    logic [ADDR_BITS-1:0] rd_len_reg;

    logic [PW-1:0]        k_inc;
    logic                 more;
    logic [IW-1:0]        rd_idx;
    logic [IW-1:0]        rd_slot;
    logic [IW-1:0]        cur_slot;
    logic [CW-1:0]        begin_ext;
    logic [CW-1:0]        len_ext;
    logic [CW-1:0]        size_ext;
    logic [ADDR_BITS-1:0] cmp_base;
    logic [CW-1:0]        alu_a;
    logic [CW-1:0]        alu_b;
    logic                 alu_sub;
    logic [CW:0]          alu_res;
    logic [CW-1:0]        gap_clamped;
    logic                 fits;
    logic                 take;
    logic                 id_match;
    logic                 ins_en;
    logic                 rem_en;
    logic                 begin_we;
    logic [IW-1:0]        begin_wa;
    logic [ADDR_BITS-1:0] begin_wd;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign k_inc    = k_reg + 1'b1;
    assign more     = (k_inc < count_reg);
    assign cur_slot = ord_reg[k_reg[IW-1:0]];
    assign rd_slot  = ord_reg[rd_idx];

    assign begin_ext = CW'(rd_begin_reg);
    assign len_ext   = CW'(rd_len_reg);
    assign size_ext  = CW'(req_reg.block_size);
    // compaction: lowest block keeps its start, others abut the previous end
    assign cmp_base  = (k_reg == '0) ? rd_begin_reg : prev_end_reg[ADDR_BITS-1:0];

    // read position: the next entry is fetched ahead of its use so the registered read has it ready
    always_comb begin
        rd_idx = k_reg[IW-1:0];
        if (state_reg == S_IDLE) begin
            rd_idx = '0;
        end else if ((state_reg == S_PICK || state_reg == S_FREE ||
                      state_reg == S_CMPCT) && more) begin
            rd_idx = k_inc[IW-1:0];
        end
    end

    // shared adder / subtractor
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_HOLE: begin
                alu_a   = begin_ext;
                alu_b   = prev_end_reg;
                alu_sub = 1'b1;
            end
            S_TAIL: begin
                alu_a   = CW'(mem_size_reg);
                alu_b   = prev_end_reg;
                alu_sub = 1'b1;
            end
            S_PICK: begin
                alu_a = begin_ext;
                alu_b = len_ext;
            end
            S_CMPCT: begin
                alu_a = CW'(cmp_base);
                alu_b = len_ext;
            end
            default: begin
            end
        endcase
    end

    assign alu_res     = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                 : ({1'b0, alu_a} + {1'b0, alu_b});
    // hole behind a block that overruns its limit counts as empty
    assign gap_clamped = alu_res[CW] ? '0 : alu_res[CW-1:0];

    // ties in best fit go to the later hole
    assign fits = (gap_reg >= size_ext);
    assign take = hole_valid_reg && fits &&
                  (!best_fit_reg || !found_reg || (gap_reg <= best_gap_reg));

    assign id_match = (rd_ident_reg == req_reg.block_id);
    assign ins_en   = (state_reg == S_COMMIT);
    assign rem_en   = (state_reg == S_FREE) && id_match;

    assign begin_we = ins_en || ((state_reg == S_CMPCT) && (k_reg != '0));
    assign begin_wa = ins_en ? free_slot_reg : cur_slot;
    assign begin_wd = ins_en ? best_pos_reg[ADDR_BITS-1:0] : cmp_base;

    // block table, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (ins_en) begin
            ident_mem[free_slot_reg] <= req_reg.block_id;
            len_mem[free_slot_reg]   <= size_ext[ADDR_BITS-1:0];
        end
        if (begin_we) begin
            begin_mem[begin_wa] <= begin_wd;
        end
        rd_ident_reg <= ident_mem[rd_slot];
        rd_begin_reg <= begin_mem[rd_slot];
        rd_len_reg   <= len_mem[rd_slot];
    end

    // order list: insert rotates the tail up, removal rotates it down
    for (genvar j = 0; j < SLOTS; j++) begin : g_ord
        logic [IW-1:0] from_below;
        logic [IW-1:0] from_above;

        if (j > 0) begin : g_below
            assign from_below = ord_reg[j-1];
        end else begin : g_below0
            assign from_below = ord_reg[j];
        end
        if (j < SLOTS - 1) begin : g_above
            assign from_above = ord_reg[j+1];
        end else begin : g_above_top
            assign from_above = ord_reg[j];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ord_reg[j] <= IW'(j);
            end else if (ins_en) begin
                if (PW'(j) == best_ins_reg) begin
                    ord_reg[j] <= free_slot_reg;
                end else if ((PW'(j) > best_ins_reg) && (PW'(j) <= count_reg)) begin
                    ord_reg[j] <= from_below;
                end
            end else if (rem_en) begin
                if (PW'(j + 1) == count_reg) begin
                    ord_reg[j] <= cur_slot;
                end else if ((PW'(j) >= k_reg) && (PW'(j + 1) < count_reg)) begin
                    ord_reg[j] <= from_above;
                end
            end
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
            mem_size_reg <= MEM_SIZE_RESET;
            best_fit_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MEMORY_SIZE:   mem_size_reg <= cfg_data;
                    REG_BEST_FIT_MODE: best_fit_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // output register empties once taken, unless the done state refills it
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg              <= s_data;
                        k_reg                <= '0;
                        found_reg            <= 1'b0;
                        hole_valid_reg       <= 1'b0;
                        tail_reg             <= 1'b0;
                        // a free on an empty table fails at once
                        res_reg.status       <= ((s_data.operation == OP_FREE) &&
                                                 (count_reg == '0)) ? ST_NOTFOUND
                                                                    : ST_DONE;
                        res_reg.placed_start <= '0;
                        unique case (s_data.operation)
                            OP_ALLOC: state_reg <= S_ALLOC;
                            OP_FREE: begin
                                if (count_reg == '0) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_FREE;
                                end
                            end
                            OP_COMPACT: begin
                                if (count_reg <= PW'(1)) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_CMPCT;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end

                S_ALLOC: begin
                    if (count_reg == PW'(SLOTS)) begin
                        res_reg.status <= ST_FULL;
                        state_reg      <= S_DONE;
                    end else begin
                        free_slot_reg <= ord_reg[count_reg[IW-1:0]];
                        if (req_reg.block_size == '0) begin
                            res_reg.status <= ST_NOFIT;
                            state_reg      <= S_DONE;
                        end else if (count_reg == '0) begin
                            // empty table: place at the bottom if it fits at all
                            if (req_reg.block_size > mem_size_reg) begin
                                res_reg.status <= ST_NOFIT;
                                state_reg      <= S_DONE;
                            end else begin
                                best_pos_reg <= '0;
                                best_ins_reg <= '0;
                                state_reg    <= S_COMMIT;
                            end
                        end else begin
                            state_reg <= S_HOLE;
                        end
                    end
                end

                S_HOLE: begin
                    // hole between previous block end and this block start
                    hole_valid_reg <= (k_reg != '0);
                    gap_reg        <= gap_clamped;
                    cand_pos_reg   <= prev_end_reg;
                    cand_ins_reg   <= k_reg;
                    state_reg      <= S_PICK;
                end

                S_TAIL: begin
                    hole_valid_reg <= 1'b1;
                    tail_reg       <= 1'b1;
                    gap_reg        <= gap_clamped;
                    cand_pos_reg   <= prev_end_reg;
                    cand_ins_reg   <= count_reg;
                    state_reg      <= S_PICK;
                end

                S_PICK: begin
                    if (take) begin
                        found_reg    <= 1'b1;
                        best_gap_reg <= gap_reg;
                        best_pos_reg <= cand_pos_reg;
                        best_ins_reg <= cand_ins_reg;
                    end
                    prev_end_reg <= alu_res[CW-1:0];
                    if (!best_fit_reg && take) begin
                        state_reg <= S_COMMIT;
                    end else if (tail_reg) begin
                        if (found_reg || take) begin
                            state_reg <= S_COMMIT;
                        end else begin
                            res_reg.status <= ST_NOFIT;
                            state_reg      <= S_DONE;
                        end
                    end else if (more) begin
                        k_reg     <= k_inc;
                        state_reg <= S_HOLE;
                    end else begin
                        state_reg <= S_TAIL;
                    end
                end

                S_COMMIT: begin
                    count_reg            <= count_reg + 1'b1;
                    res_reg.status       <= ST_DONE;
                    res_reg.placed_start <= best_pos_reg[FIELD_W-1:0];
                    state_reg            <= S_DONE;
                end

                S_FREE: begin
                    // lowest-addressed block with the id goes
                    if (id_match) begin
                        count_reg      <= count_reg - 1'b1;
                        res_reg.status <= ST_DONE;
                        state_reg      <= S_DONE;
                    end else if (more) begin
                        k_reg <= k_inc;
                    end else begin
                        res_reg.status <= ST_NOTFOUND;
                        state_reg      <= S_DONE;
                    end
                end

                S_CMPCT: begin
                    prev_end_reg <= alu_res[CW-1:0];
                    if (more) begin
                        k_reg <= k_inc;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // table never overfills
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PW'(SLOTS))
        else $error("block count above table depth");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in flight");

    // count moves only on placement or removal
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == S_COMMIT || $past(state_reg) == S_FREE))
        else $error("block count changed outside placement or removal");

    // failed or non-placing responses carry a zero start
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_DONE)) |-> (m_data.placed_start == '0))
        else $error("non-zero start on failed response");

    // response appears only from the done state
    a_resp_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == S_DONE))
        else $error("response raised outside done state");

endmodule

`default_nettype wire

>>> sim/cfba_allocation_checker.sv
// response checker for the contiguous allocator: mirrors its table and compares every response
`timescale 1ns / 1ps

module cfba_allocation_checker
    import cfba_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire cfba_req_t              s_data,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire cfba_resp_t             m_data,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatch_count,
    output int                          responses_owed,
    output int                          responses_checked
);

    // shadow of the block table and its settings
    logic               slot_used  [SLOTS];
    logic [FIELD_W-1:0] slot_owner [SLOTS];
    logic [FIELD_W-1:0] slot_base  [SLOTS];
    logic [FIELD_W-1:0] slot_len   [SLOTS];
    logic [FIELD_W-1:0] mem_units;
    logic               smallest_fit;

    int         addr_order [SLOTS];
    cfba_resp_t awaited_responses [$];
    int         mismatches;
    int         checked;

    // live slots in address order, ties by slot number; returns how many
    function automatic int sort_live();
        int n;
        int i;
        int j;
        n = 0;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
                j = n;
                while (j > 0 && slot_base[addr_order[j-1]] > slot_base[i]) begin
                    addr_order[j] = addr_order[j-1];
                    j--;
                end
                addr_order[j] = i;
                n++;
            end
        end
        return n;
    endfunction

    function automatic cfba_resp_t place_block(input logic [FIELD_W-1:0] id,
                                               input logic [FIELD_W-1:0] size);
        cfba_resp_t  resp;
        int          spare;
        int          n;
        int          k;
        logic        found;
        logic [31:0] fin;
        logic [31:0] lim;
        logic [31:0] gap;
        logic [31:0] best_gap;
        logic [31:0] pos;
        resp.status       = ST_DONE;
        resp.placed_start = '0;
        spare             = SLOTS;
        for (k = SLOTS - 1; k >= 0; k--) begin
            if (!slot_used[k])
                spare = k;
        end
        if (spare == SLOTS) begin
            resp.status = ST_FULL;
            return resp;
        end
        if (size == 0) begin
            resp.status = ST_NOFIT;
            return resp;
        end
        n        = sort_live();
        found    = 1'b0;
        best_gap = '0;
        pos      = '0;
        if (n == 0) begin
            found = (size <= mem_units);
        end else begin
            // holes only follow live blocks; first fit stops at the first one that fits
            for (k = 0; k < n && !(found && !smallest_fit); k++) begin
                fin = slot_base[addr_order[k]] + slot_len[addr_order[k]];
                lim = (k + 1 < n) ? slot_base[addr_order[k+1]] : mem_units;
                gap = (lim > fin) ? lim - fin : '0;
                if (gap >= size && (!found || gap <= best_gap)) begin
                    best_gap = gap;
                    pos      = fin;
                    found    = 1'b1;
                end
            end
        end
        if (!found) begin
            resp.status = ST_NOFIT;
            return resp;
        end
        slot_used[spare]  = 1'b1;
        slot_owner[spare] = id;
        slot_base[spare]  = pos[FIELD_W-1:0];
        slot_len[spare]   = size;
        resp.placed_start = pos[FIELD_W-1:0];
        return resp;
    endfunction

    // lowest-addressed live block with a matching id goes
    function automatic logic [1:0] release_block(input logic [FIELD_W-1:0] id);
        int n;
        int k;
        n = sort_live();
        for (k = 0; k < n; k++) begin
            if (slot_owner[addr_order[k]] == id) begin
                slot_used[addr_order[k]] = 1'b0;
                return ST_DONE;
            end
        end
        return ST_NOTFOUND;
    endfunction

    function automatic void compact_blocks();
        int n;
        int k;
        n = sort_live();
        for (k = 1; k < n; k++)
            slot_base[addr_order[k]] = slot_base[addr_order[k-1]] + slot_len[addr_order[k-1]];
    endfunction

    function automatic cfba_resp_t apply_request(input cfba_req_t req);
        cfba_resp_t resp;
        resp = '0;
        case (req.operation)
            OP_ALLOC:   resp = place_block(req.block_id, req.block_size);
            OP_FREE:    resp.status = release_block(req.block_id);
            OP_COMPACT: compact_blocks();
            default:    resp.status = ST_DONE;
        endcase
        return resp;
    endfunction

    always @(posedge aclk) begin
        cfba_resp_t want;
        int         i;
        if (!aresetn) begin
            for (i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            mem_units    = MEM_SIZE_RESET;
            smallest_fit = 1'b0;
            mismatches   = 0;
            checked      = 0;
            awaited_responses.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_responses.size() == 0) begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected response: status %0d start %0d",
                                 $time, m_data.status, m_data.placed_start);
                    mismatches++;
                end else begin
                    want = awaited_responses.pop_front();
                    checked++;
                    if (m_data.status !== want.status ||
                        m_data.placed_start !== want.placed_start) begin
                        if (mismatches < 10)
                            $display("[%0t] mismatch: expected status %0d start %0d,",
                                     $time, want.status, want.placed_start,
                                     " got status %0d start %0d",
                                     m_data.status, m_data.placed_start);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MEMORY_SIZE:   mem_units    = cfg_data[FIELD_W-1:0];
                    REG_BEST_FIT_MODE: smallest_fit = cfg_data[0];
                    default:           ;
                endcase
            end
            if (s_valid && s_ready)
                awaited_responses.push_back(apply_request(s_data));
        end
        mismatch_count    <= mismatches;
        responses_checked <= checked;
        responses_owed    <= awaited_responses.size();
    end

endmodule

>>> sim/testbench.sv
// testbench top for the contiguous allocator: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
    import cfba_pkg::*;

    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         HOLDOFF_CYCLES = 400;
    localparam int         SETTLE_CYCLES  = 60;
    localparam int         DRAIN_CYCLES   = 80;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    cfba_req_t              s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    cfba_resp_t             m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MEMORY_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int   mismatch_count;
    int   responses_owed;
    int   responses_checked;

    // idling knobs, changed per phase
    int   s_idle_pct   = 0;
    int   m_stall_pct  = 0;
    logic hold_request = 1'b0;
    int   quiet_cycles = 0;
    int   op_count [4];

    always #6 aclk = ~aclk;

    contiguous_first_best_fit_allocator_unit #(
        .SLOTS     (16),
        .ADDR_BITS (16)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfba_allocation_checker #(
        .SLOTS (16)
    ) response_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .responses_owed    (responses_owed),
        .responses_checked (responses_checked)
    );

    // receiver: random stalls, or a long hold-off when asked, counted here
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request <= 1'b0;
                m_ready      <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= m_stall_pct);
            end
        end
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cfba_req_t make_request(input logic [1:0] op,
                                               input logic [FIELD_W-1:0] id,
                                               input logic [FIELD_W-1:0] size);
        cfba_req_t req;
        req.operation  = op;
        req.block_id   = id;
        req.block_size = size;
        return req;
    endfunction

    // mostly allocate and free over a small id pool so frees tend to hit live blocks
    function automatic cfba_req_t random_request(input logic [FIELD_W-1:0] units);
        cfba_req_t req;
        int        pick;
        pick           = $urandom_range(99);
        req.block_id   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
        req.block_size = 16'($urandom);
        if (pick < 50) begin
            req.operation = OP_ALLOC;
            case ($urandom_range(9))
                0:       req.block_size = '0;
                1:       ;  // full-range size, mostly too large
                2:       req.block_size = units;
                default: req.block_size = 16'($urandom_range(units / 6 + 1, 1));
            endcase
        end else if (pick < 88) begin
            req.operation = OP_FREE;
        end else if (pick < 97) begin
            req.operation = OP_COMPACT;
        end else begin
            req.operation = OP_UNUSED;
        end
        return req;
    endfunction

    // valid stays high from one transaction to the next unless an idle gap is drawn
    task automatic send_request(input cfba_req_t req);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        op_count[req.operation] = op_count[req.operation] + 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (responses_owed != 0);
    endtask

    task automatic write_config(input logic [FIELD_W-1:0] units, input logic fit_best);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MEMORY_SIZE;
        cfg_data  <= units;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_BEST_FIT_MODE;
        cfg_data  <= CFG_DATA_W'(fit_best);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // reconfigure once idle, then a burst of random requests; the table carries over
    task automatic run_phase(input logic [FIELD_W-1:0] units, input logic fit_best,
                             input int idle_pct, input int stall_pct, input int count,
                             input int hold_at, input int pause_at);
        int k;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_config(units, fit_best);
        s_idle_pct  = idle_pct;
        m_stall_pct = stall_pct;
        for (k = 0; k < count; k++) begin
            if (k == hold_at)
                hold_request <= 1'b1;
            if (k == pause_at)
                wait_drained();
            send_request(random_request(units));
        end
    endtask

    initial begin
        int k;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings: 1024 units, first fit
        send_request(make_request(OP_ALLOC, 16'd0, 16'd0));          // zero size
        send_request(make_request(OP_ALLOC, 16'd9, 16'hFFFF));        // too large for empty memory
        send_request(make_request(OP_FREE, 16'h1234, 16'd0));         // nothing to free
        send_request(make_request(OP_ALLOC, 16'd1, 16'd100));         // empty table, goes at 0
        send_request(make_request(OP_ALLOC, 16'd2, 16'd100));
        send_request(make_request(OP_ALLOC, 16'd3, 16'd100));
        send_request(make_request(OP_ALLOC, 16'd1, 16'd50));          // duplicate id
        send_request(make_request(OP_FREE, 16'd1, 16'hFFFF));         // lower copy goes
        send_request(make_request(OP_ALLOC, 16'd4, 16'd10));          // gap below lowest unused
        send_request(make_request(OP_FREE, 16'd3, 16'd0));
        send_request(make_request(OP_COMPACT, 16'hFFFF, 16'hFFFF));   // lowest block stays put
        send_request(make_request(OP_UNUSED, 16'hFFFF, 16'hFFFF));
        for (k = 0; k < 13; k++)
            send_request(make_request(OP_ALLOC, (k == 12) ? 16'hFFFF : 16'(16 + k),
                                      16'(k + 1)));
        send_request(make_request(OP_ALLOC, 16'd0, 16'hFFFF));        // table full

        // random phases over several settings, extremes included
        run_phase(16'hFFFF, 1'b1, 0, 0, 170, -1, -1);
        run_phase(16'd1, 1'b0, 66, 0, 60, -1, -1);                    // memory shrunk under live blocks
        run_phase(16'd500, 1'b1, 0, 66, 170, -1, -1);
        run_phase(16'd2000, 1'b0, 10, 10, 170, 80, -1);               // long receiver hold-off
        run_phase(16'd120, 1'b1, 0, 0, 190, -1, 95);                  // sender pause until drained
        run_phase(16'hFFFF, 1'b0, 0, 66, 170, -1, -1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d requests (%0d allocate, %0d free, %0d compact, %0d unused code)",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_COMPACT],
                 op_count[OP_UNUSED]);
        $display("over six memory size and fit mode settings; %0d responses compared, %0d bad",
                 responses_checked, mismatch_count);
        if (mismatch_count == 0 && responses_owed == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
